[rtl/fpr_pkg.sv]
// Shared types and constants for the FIFO page replacement core.
package fpr_pkg;

  localparam int COUNT_W    = 32;
  localparam int CFG_W      = 5;
  localparam int SLOT_OUT_W = 4;

  localparam logic [CFG_W-1:0]   FRAMES_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } fpr_cmd_t;

  typedef struct packed {
    logic out_busy;
  } fpr_status_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (v == COUNT_MAX) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

[rtl/fpr_ctrl.sv]
// Sequencer for the FIFO page replacement core: capture, lookup, commit.
module fpr_ctrl
  import fpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  fpr_status_t status,
  output fpr_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/fpr_datapath.sv]
// Frame table, parallel page search, insert pointer, counters and result register.
module fpr_datapath
  import fpr_pkg::*;
#(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fpr_cmd_t              cmd,
  output fpr_status_t           status,
  input  logic [PAGE_BITS-1:0]  page_number,
  input  logic                  cfg_valid,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic                  was_hit,
  output logic [SLOT_OUT_W-1:0] slot,
  output logic [COUNT_W-1:0]    hit_count,
  output logic [COUNT_W-1:0]    fault_count
);

  localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int WIDE_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'(MAX_FRAMES);

  logic [CFG_W-1:0]     frames_in_use;
  logic [PAGE_BITS-1:0] frame_pages [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] frame_valid;
  logic [SLOT_W-1:0]    insert_ptr;
  logic [COUNT_W-1:0]   hits;
  logic [COUNT_W-1:0]   faults;
  logic [PAGE_BITS-1:0] page;
  logic                 hit;
  logic [SLOT_W-1:0]    found;

  logic [WIDE_W-1:0]     cfg_wide;
  logic [CNT_W-1:0]      active;
  logic [MAX_FRAMES-1:0] match;
  logic                  match_any;
  logic [SLOT_W-1:0]     match_slot;
  logic [SLOT_W-1:0]     fill_slot;
  logic [CNT_W-1:0]      fill_plus;
  logic [SLOT_W-1:0]     ptr_next;
  logic [COUNT_W-1:0]    hits_inc;
  logic [COUNT_W-1:0]    faults_inc;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;

  // effective frame count: zero acts as one, clamp at MAX_FRAMES
  always_comb begin
    cfg_wide = WIDE_W'(frames_in_use);
    if (cfg_wide == '0) begin
      active = CNT_W'(1);
    end else if (cfg_wide > MAX_WIDE) begin
      active = CNT_W'(MAX_FRAMES);
    end else begin
      active = cfg_wide[CNT_W-1:0];
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_FRAMES; j++) begin
      match[j] = frame_valid[j] && (CNT_W'(j) < active) && (frame_pages[j] == page);
    end
    match_any  = |match;
    match_slot = '0;
    for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
      if (match[j]) begin
        match_slot = SLOT_W'(j);
      end
    end
  end

  always_comb begin
    fill_slot = (CNT_W'(insert_ptr) >= active) ? '0 : insert_ptr;
    fill_plus = CNT_W'(fill_slot) + CNT_W'(1);
    ptr_next  = (fill_plus >= active) ? '0 : fill_plus[SLOT_W-1:0];
    hits_inc   = sat_inc(hits);
    faults_inc = sat_inc(faults);
  end

  assign status.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page <= page_number;
    end
    if (cmd.lookup) begin
      hit   <= match_any;
      found <= match_slot;
    end
    if (cmd.commit && !hit) begin
      frame_pages[fill_slot] <= page;
    end
    if (cmd.commit) begin
      was_hit <= hit;
      if (hit) begin
        slot_wide   <= {{SLOT_OUT_W{1'b0}}, found};
        hit_count   <= hits_inc;
        fault_count <= faults;
      end else begin
        slot_wide   <= {{SLOT_OUT_W{1'b0}}, fill_slot};
        hit_count   <= hits;
        fault_count <= faults_inc;
      end
    end
  end

  assign slot = slot_wide[SLOT_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
      frame_valid   <= '0;
      insert_ptr    <= '0;
      hits          <= '0;
      faults        <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        frames_in_use <= cfg_data;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (hit) begin
          hits <= hits_inc;
        end else begin
          frame_valid[fill_slot] <= 1'b1;
          insert_ptr             <= ptr_next;
          faults                 <= faults_inc;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/fifo_page_replacement_core.sv]
// Top level of the FIFO page replacement core.
// Usage:
//   Input channel (in_valid / in_stall / page_number) carries one page reference
//   per transfer. Output channel (out_valid / out_stall) returns one result per
//   reference: was_hit, slot found or filled, and saturating hit and fault counts.
//   Config channel (cfg_valid / cfg_ready / cfg_data) sets the number of frames in
//   use; cfg_ready is always high. Write it only while the core is idle.
// Sequence:
//   Each reference passes through capture, parallel search over the frames in use,
//   then commit of the table update into the result register, which sets out_valid.
//   After a capture the input stalls until that reference has committed.
//   The result register frees the input side: the next reference is taken while
//   a result still waits, and its commit waits until that result is transferred.
// Reset (rst, synchronous): all frames empty, insert pointer and counts zero,
//   frame count 16, no result pending.
module fifo_page_replacement_core
  import fpr_pkg::*;
#(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PAGE_BITS-1:0]  page_number,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  was_hit,
  output logic [SLOT_OUT_W-1:0] slot,
  output logic [COUNT_W-1:0]    hit_count,
  output logic [COUNT_W-1:0]    fault_count
);

  fpr_cmd_t    cmd;
  fpr_status_t status;

  assign cfg_ready = 1'b1;

  fpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fpr_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .page_number (page_number),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .was_hit     (was_hit),
    .slot        (slot),
    .hit_count   (hit_count),
    .fault_count (fault_count)
  );

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous reference in flight");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("commit overwrote a stalled result");

  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result appeared without commit");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.lookup, cmd.commit}))
    else $error("overlapping datapath commands");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the FIFO page replacement core: directed and random page traffic.
`timescale 1ns / 100ps

module testbench
  import fpr_pkg::*;
();

  localparam int NUM_FRAMES  = 16;
  localparam int PAGE_W      = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic [COUNT_W-1:0]    hits;
    logic [COUNT_W-1:0]    faults;
  } lookup_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PAGE_W-1:0]     page_number = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  was_hit;
  logic [SLOT_OUT_W-1:0] slot;
  logic [COUNT_W-1:0]    hit_count;
  logic [COUNT_W-1:0]    fault_count;

  fifo_page_replacement_core #(
    .MAX_FRAMES(NUM_FRAMES),
    .PAGE_BITS (PAGE_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .page_number(page_number),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .was_hit    (was_hit),
    .slot       (slot),
    .hit_count  (hit_count),
    .fault_count(fault_count)
  );

  // Predicted frame table
  logic [PAGE_W-1:0]  frame_page [NUM_FRAMES];
  logic               frame_used [NUM_FRAMES] = '{default: 1'b0};
  int                 fill_ptr = 0;
  logic [COUNT_W-1:0] hit_tally = '0;
  logic [COUNT_W-1:0] fault_tally = '0;
  logic [CFG_W-1:0]   frames_cfg = FRAMES_RESET;

  lookup_result_t expected_results [$];
  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  function automatic lookup_result_t resolve_reference(input logic [PAGE_W-1:0] pg);
    lookup_result_t r;
    int n;
    int idx;
    int j;
    n = (frames_cfg == 0) ? 1 : (frames_cfg > NUM_FRAMES) ? NUM_FRAMES : int'(frames_cfg);
    idx = -1;
    for (j = 0; j < n; j++)
      if (idx < 0 && frame_used[j] && frame_page[j] == pg) idx = j;
    r.hit = (idx >= 0);
    if (r.hit) begin
      if (hit_tally != COUNT_MAX) hit_tally = hit_tally + 1'b1;
    end else begin
      idx = (fill_ptr >= n) ? 0 : fill_ptr;
      frame_page[idx] = pg;
      frame_used[idx] = 1'b1;
      if (fault_tally != COUNT_MAX) fault_tally = fault_tally + 1'b1;
      fill_ptr = (idx + 1 >= n) ? 0 : idx + 1;
    end
    r.slot   = idx[SLOT_OUT_W-1:0];
    r.hits   = hit_tally;
    r.faults = fault_tally;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [COUNT_W-1:0] want,
                                      input logic [COUNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: hit=%0d slot=%0d hits=%0d faults=%0d",
                 $time, was_hit, slot, hit_count, fault_count);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("was_hit", COUNT_W'(want.hit), COUNT_W'(was_hit));
        check_field("slot", COUNT_W'(want.slot), COUNT_W'(slot));
        check_field("hit_count", want.hits, hit_count);
        check_field("fault_count", want.faults, fault_count);
      end
    end
  end

  // One page reference transfer, with a random gap ahead of it
  task automatic send_page(input logic [PAGE_W-1:0] pg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    page_number <= pg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(resolve_reference(pg));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_frames(input logic [CFG_W-1:0] n);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    frames_cfg = n;
  endtask

  task automatic test_extreme_pages();
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h5555);
    send_page(16'hAAAA);
  endtask

  // Single frame, pointer past the count, duplicates, zero and oversized counts
  task automatic test_frame_count_cases();
    set_frames(5'd1);
    send_page(16'h5555);
    send_page(16'h5555);
    send_page(16'hFFFF);
    set_frames(5'd31);
    send_page(16'hFFFF);
    send_page(16'h1234);
    send_page(16'h0000);
    set_frames(5'd0);
    send_page(16'h0001);
    send_page(16'h0001);
    send_page(16'hAAAA);
    set_frames(5'd17);
    send_page(16'h8000);
    send_page(16'hAAAA);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    logic [PAGE_W-1:0] pool [24];
    logic [CFG_W-1:0]  n;
    int pool_n;
    int chunk;
    int sent;
    int k;
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(5))
        0: n = 5'd1;
        1: n = 5'd16;
        2: n = 5'd0;
        3: n = 5'($urandom_range(17, 31));
        default: n = 5'($urandom_range(1, 16));
      endcase
      set_frames(n);
      pool_n = $urandom_range(1, 24);
      for (k = 0; k < pool_n; k++) pool[k] = PAGE_W'($urandom);
      chunk = $urandom_range(24, 72);
      for (k = 0; k < chunk && sent < count; k++) begin
        if ($urandom_range(9) < 8) send_page(pool[$urandom_range(pool_n - 1)]);
        else send_page(PAGE_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 33;
    stall_pct     = 76;
    test_extreme_pages();
    test_frame_count_cases();
    test_random_traffic(33, 76, 384);
    test_random_traffic(76, 33, 384);
    test_random_traffic(0, 0, 384);
    drain_results();
    if (expected_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
